FILE: design/order_book_price_level_table_unit_assert.svh
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define OBPLT_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("order book assertion failed");

// next-cycle implication
`define OBPLT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("order book assertion failed");

`endif

FILE: design/obplt_pkg.sv
package obplt_pkg;

    localparam int LEVELS     = 64;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int COUNT_BITS = $clog2(LEVELS + 1);

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        logic                  remove;
        logic                  update;
        logic                  insert;
        logic                  descending;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } cell_ctl_t;

    typedef struct packed {
        logic match;
        logic shift;
    } cell_stat_t;

    typedef struct packed {
        logic                  apply;
        logic                  clear;
        logic                  descending;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } side_cmd_t;

    typedef struct packed {
        status_t               status;
        logic [PRICE_BITS-1:0] best_price;
        logic [QTY_BITS-1:0]   best_qty;
        logic [COUNT_BITS-1:0] count;
    } side_res_t;

endpackage

FILE: design/order_book_price_level_table_unit.sv
// Two sorted price-level books (bids high to low, asks low to high), each a
// row of 64 cells that compare the incoming price in parallel and shift
// toward their neighbors on insert or remove. One transaction is accepted
// per clock; its status, both best levels and both level counts appear in
// the output register on the next cycle. Input stalls only while a result
// sits unaccepted in the output register. A clear only zeroes the level
// counts; no sweep of the cells is needed after reset.
module order_book_price_level_table_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic                             side,
    input  logic [obplt_pkg::PRICE_BITS-1:0] level_price,
    input  logic [obplt_pkg::QTY_BITS-1:0]   level_quantity,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic [obplt_pkg::PRICE_BITS-1:0] best_bid_price,
    output logic [obplt_pkg::QTY_BITS-1:0]   best_bid_quantity,
    output logic [obplt_pkg::PRICE_BITS-1:0] best_ask_price,
    output logic [obplt_pkg::QTY_BITS-1:0]   best_ask_quantity,
    output logic [obplt_pkg::COUNT_BITS-1:0] bid_levels,
    output logic [obplt_pkg::COUNT_BITS-1:0] ask_levels
);

    logic                 accept;
    obplt_pkg::side_cmd_t bid_cmd;
    obplt_pkg::side_cmd_t ask_cmd;
    obplt_pkg::side_res_t bid_res;
    obplt_pkg::side_res_t ask_res;
    obplt_pkg::status_t   status_sel;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    obplt_pkg::status_t               status_reg;
    logic [obplt_pkg::PRICE_BITS-1:0] bid_price_reg;
    logic [obplt_pkg::QTY_BITS-1:0]   bid_qty_reg;
    logic [obplt_pkg::PRICE_BITS-1:0] ask_price_reg;
    logic [obplt_pkg::QTY_BITS-1:0]   ask_qty_reg;
    logic [obplt_pkg::COUNT_BITS-1:0] bid_count_reg;
    logic [obplt_pkg::COUNT_BITS-1:0] ask_count_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        bid_cmd.apply      = accept && !op && !side;
        bid_cmd.clear      = accept && op;
        bid_cmd.descending = 1'b1;
        bid_cmd.price      = level_price;
        bid_cmd.qty        = level_quantity;
        ask_cmd.apply      = accept && !op && side;
        ask_cmd.clear      = accept && op;
        ask_cmd.descending = 1'b0;
        ask_cmd.price      = level_price;
        ask_cmd.qty        = level_quantity;
    end

    obplt_side u_bid (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bid_cmd),
        .res   (bid_res)
    );

    obplt_side u_ask (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ask_cmd),
        .res   (ask_res)
    );

    always_comb
    begin
        if (op)
        begin
            status_sel = obplt_pkg::ST_CLEARED;
        end
        else if (side)
        begin
            status_sel = ask_res.status;
        end
        else
        begin
            status_sel = bid_res.status;
        end
        out_valid_next = accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_sel;
            bid_price_reg <= bid_res.best_price;
            bid_qty_reg   <= bid_res.best_qty;
            ask_price_reg <= ask_res.best_price;
            ask_qty_reg   <= ask_res.best_qty;
            bid_count_reg <= bid_res.count;
            ask_count_reg <= ask_res.count;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign best_bid_price    = bid_price_reg;
    assign best_bid_quantity = bid_qty_reg;
    assign best_ask_price    = ask_price_reg;
    assign best_ask_quantity = ask_qty_reg;
    assign bid_levels        = bid_count_reg;
    assign ask_levels        = ask_count_reg;

endmodule

FILE: design/obplt_cell.sv
module obplt_cell (
    input  logic                             clk,
    input  obplt_pkg::cell_ctl_t             ctl,
    input  logic                             occupied,
    input  logic [obplt_pkg::PRICE_BITS-1:0] left_price,
    input  logic [obplt_pkg::QTY_BITS-1:0]   left_qty,
    input  logic                             left_shift,
    input  logic [obplt_pkg::PRICE_BITS-1:0] right_price,
    input  logic [obplt_pkg::QTY_BITS-1:0]   right_qty,
    output logic [obplt_pkg::PRICE_BITS-1:0] price,
    output logic [obplt_pkg::QTY_BITS-1:0]   qty,
    output logic [obplt_pkg::PRICE_BITS-1:0] price_next,
    output logic [obplt_pkg::QTY_BITS-1:0]   qty_next,
    output obplt_pkg::cell_stat_t            stat
);

    logic [obplt_pkg::PRICE_BITS-1:0] price_reg;
    logic [obplt_pkg::QTY_BITS-1:0]   qty_reg;
    logic                             better;

    assign price = price_reg;
    assign qty   = qty_reg;

    always_comb
    begin
        better = occupied && (ctl.descending ? (price_reg > ctl.price)
                                             : (price_reg < ctl.price));
        stat.match = occupied && (price_reg == ctl.price);
        stat.shift = !better;
        price_next = price_reg;
        qty_next   = qty_reg;
        if (ctl.remove)
        begin
            // matching cell and everything behind it pull from the right
            if (occupied && !better)
            begin
                price_next = right_price;
                qty_next   = right_qty;
            end
        end
        else if (ctl.update)
        begin
            if (stat.match)
            begin
                qty_next = ctl.qty;
            end
        end
        else if (ctl.insert)
        begin
            if (!better)
            begin
                if (left_shift)
                begin
                    price_next = left_price;
                    qty_next   = left_qty;
                end
                else
                begin
                    price_next = ctl.price;
                    qty_next   = ctl.qty;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

FILE: design/obplt_side.sv
module obplt_side (
    input  logic                 clk,
    input  logic                 rst_n,
    input  obplt_pkg::side_cmd_t cmd,
    output obplt_pkg::side_res_t res
);

    localparam int N = obplt_pkg::LEVELS;

    logic [obplt_pkg::COUNT_BITS-1:0] count_reg;
    logic [obplt_pkg::COUNT_BITS-1:0] count_next;

    logic [obplt_pkg::PRICE_BITS-1:0] cell_price [N];
    logic [obplt_pkg::QTY_BITS-1:0]   cell_qty [N];
    logic [obplt_pkg::PRICE_BITS-1:0] cell_price_next [N];
    logic [obplt_pkg::QTY_BITS-1:0]   cell_qty_next [N];
    obplt_pkg::cell_stat_t            cell_stat [N];
    logic [N-1:0]                     match_vec;
    logic [N-1:0]                     shift_vec;

    logic                 found;
    logic                 full;
    logic                 qty_zero;
    obplt_pkg::cell_ctl_t ctl;

    always_comb
    begin
        qty_zero       = (cmd.qty == '0);
        found          = |match_vec;
        full           = (count_reg == obplt_pkg::COUNT_BITS'(N));
        ctl.descending = cmd.descending;
        ctl.price      = cmd.price;
        ctl.qty        = cmd.qty;
        ctl.remove     = cmd.apply && qty_zero && found;
        ctl.update     = cmd.apply && !qty_zero && found;
        ctl.insert     = cmd.apply && !qty_zero && !found && !full;
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic [obplt_pkg::PRICE_BITS-1:0] lp;
            logic [obplt_pkg::QTY_BITS-1:0]   lq;
            logic                             ls;
            logic [obplt_pkg::PRICE_BITS-1:0] rp;
            logic [obplt_pkg::QTY_BITS-1:0]   rq;
            logic                             occ;

            assign occ = (obplt_pkg::COUNT_BITS'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign lp = '0;
                assign lq = '0;
                assign ls = 1'b0;
            end
            else
            begin : g_mid
                assign lp = cell_price[i-1];
                assign lq = cell_qty[i-1];
                assign ls = shift_vec[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign rp = '0;
                assign rq = '0;
            end
            else
            begin : g_inner
                assign rp = cell_price[i+1];
                assign rq = cell_qty[i+1];
            end

            obplt_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occ),
                .left_price  (lp),
                .left_qty    (lq),
                .left_shift  (ls),
                .right_price (rp),
                .right_qty   (rq),
                .price       (cell_price[i]),
                .qty         (cell_qty[i]),
                .price_next  (cell_price_next[i]),
                .qty_next    (cell_qty_next[i]),
                .stat        (cell_stat[i])
            );

            assign match_vec[i] = cell_stat[i].match;
            assign shift_vec[i] = cell_stat[i].shift;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        res.status = obplt_pkg::ST_CLEARED;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - obplt_pkg::COUNT_BITS'(1);
            res.status = obplt_pkg::ST_REMOVED;
        end
        else if (ctl.update)
        begin
            res.status = obplt_pkg::ST_UPDATED;
        end
        else if (ctl.insert)
        begin
            count_next = count_reg + obplt_pkg::COUNT_BITS'(1);
            res.status = obplt_pkg::ST_INSERTED;
        end
        else if (qty_zero)
        begin
            res.status = obplt_pkg::ST_ABSENT;
        end
        else
        begin
            res.status = obplt_pkg::ST_FULL;
        end
        res.count      = count_next;
        res.best_price = (count_next != '0) ? cell_price_next[0] : '0;
        res.best_qty   = (count_next != '0) ? cell_qty_next[0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/obplt_checker.sv
`include "order_book_price_level_table_unit_assert.svh"

module obplt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             op,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [2:0]                       status,
    input logic [obplt_pkg::PRICE_BITS-1:0] best_bid_price,
    input logic [obplt_pkg::QTY_BITS-1:0]   best_bid_quantity,
    input logic [obplt_pkg::COUNT_BITS-1:0] bid_levels,
    input logic [obplt_pkg::COUNT_BITS-1:0] ask_levels
);

    localparam logic [obplt_pkg::COUNT_BITS-1:0] LEVEL_CAP =
        obplt_pkg::COUNT_BITS'(obplt_pkg::LEVELS);

    logic in_accept;
    logic cleared_view;
    logic bid_blank;

    assign in_accept    = in_valid && !in_stall;
    assign cleared_view = (status == obplt_pkg::ST_CLEARED) && (bid_levels == '0)
                          && (ask_levels == '0);
    assign bid_blank    = (best_bid_price == '0) && (best_bid_quantity == '0);

    `OBPLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `OBPLT_ASSERT_NEXT(a_clear_result, in_accept && op, out_valid && cleared_view)
    `OBPLT_ASSERT_NOW(a_empty_bid, out_valid && bid_levels == '0, bid_blank)
    `OBPLT_ASSERT_NOW(a_count_range, out_valid, bid_levels <= LEVEL_CAP && ask_levels <= LEVEL_CAP)
    `OBPLT_ASSERT_NOW(a_full_drop, out_valid && status == obplt_pkg::ST_FULL, bid_levels == LEVEL_CAP || ask_levels == LEVEL_CAP)

endmodule

bind order_book_price_level_table_unit obplt_checker u_checker (.*);

FILE: dv/tb.sv
module tb;

    import obplt_pkg::*;

    typedef enum logic {OP_LEVEL = 1'b0, OP_CLEAR = 1'b1} book_op_t;
    typedef enum logic {SIDE_BID = 1'b0, SIDE_ASK = 1'b1} book_side_t;

    typedef struct {
        book_op_t              op;
        book_side_t            side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } book_item_t;

    typedef struct {
        status_t               status;
        logic [PRICE_BITS-1:0] bid_price;
        logic [QTY_BITS-1:0]   bid_qty;
        logic [PRICE_BITS-1:0] ask_price;
        logic [QTY_BITS-1:0]   ask_qty;
        logic [COUNT_BITS-1:0] bid_count;
        logic [COUNT_BITS-1:0] ask_count;
    } book_view_t;

    localparam int CALM_TAIL = 200;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;
    localparam logic [QTY_BITS-1:0]   QTY_MAX   = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = 1'b0;
    logic                  side = 1'b0;
    logic [PRICE_BITS-1:0] level_price = '0;
    logic [QTY_BITS-1:0]   level_quantity = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            status;
    logic [PRICE_BITS-1:0] best_bid_price;
    logic [QTY_BITS-1:0]   best_bid_quantity;
    logic [PRICE_BITS-1:0] best_ask_price;
    logic [QTY_BITS-1:0]   best_ask_quantity;
    logic [COUNT_BITS-1:0] bid_levels;
    logic [COUNT_BITS-1:0] ask_levels;

    order_book_price_level_table_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .side              (side),
        .level_price       (level_price),
        .level_quantity    (level_quantity),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .best_bid_price    (best_bid_price),
        .best_bid_quantity (best_bid_quantity),
        .best_ask_price    (best_ask_price),
        .best_ask_quantity (best_ask_quantity),
        .bid_levels        (bid_levels),
        .ask_levels        (ask_levels)
    );

    always #5 clk = ~clk;

    // shadow book: index 0 is bids, 1 is asks; entry 0 is the best level
    logic [PRICE_BITS-1:0] shadow_px [2][LEVELS];
    logic [QTY_BITS-1:0]   shadow_qt [2][LEVELS];
    int                    shadow_cnt [2];

    book_item_t pending_items[$];
    book_view_t expected_views[$];
    book_item_t driven_item;
    int         gap_left = 0;
    int         stall_left = 0;
    int         mismatches = 0;

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic status_t apply_level_update(input int s,
                                                   input logic [PRICE_BITS-1:0] price,
                                                   input logic [QTY_BITS-1:0] qty);
        int n;
        int hit;
        int pos;
        n = shadow_cnt[s];
        hit = n;
        for (int i = 0; i < n; i++)
        begin
            if (hit == n && shadow_px[s][i] == price)
                hit = i;
        end
        if (qty == '0)
        begin
            if (hit == n)
                return ST_ABSENT;
            for (int i = hit; i + 1 < n; i++)
            begin
                shadow_px[s][i] = shadow_px[s][i+1];
                shadow_qt[s][i] = shadow_qt[s][i+1];
            end
            shadow_cnt[s] = n - 1;
            return ST_REMOVED;
        end
        if (hit < n)
        begin
            shadow_qt[s][hit] = qty;
            return ST_UPDATED;
        end
        if (n >= LEVELS)
            return ST_FULL;
        pos = 0;
        while (pos < n && ((s == 0) ? shadow_px[s][pos] > price : shadow_px[s][pos] < price))
            pos++;
        for (int i = n; i > pos; i--)
        begin
            shadow_px[s][i] = shadow_px[s][i-1];
            shadow_qt[s][i] = shadow_qt[s][i-1];
        end
        shadow_px[s][pos] = price;
        shadow_qt[s][pos] = qty;
        shadow_cnt[s] = n + 1;
        return ST_INSERTED;
    endfunction

    function automatic book_view_t predict_book_view(input book_item_t it);
        book_view_t v;
        if (it.op == OP_CLEAR)
        begin
            shadow_cnt[0] = 0;
            shadow_cnt[1] = 0;
            v.status = ST_CLEARED;
        end
        else
            v.status = apply_level_update((it.side == SIDE_ASK) ? 1 : 0, it.price, it.qty);
        v.bid_price = (shadow_cnt[0] != 0) ? shadow_px[0][0] : '0;
        v.bid_qty   = (shadow_cnt[0] != 0) ? shadow_qt[0][0] : '0;
        v.ask_price = (shadow_cnt[1] != 0) ? shadow_px[1][0] : '0;
        v.ask_qty   = (shadow_cnt[1] != 0) ? shadow_qt[1][0] : '0;
        v.bid_count = COUNT_BITS'(shadow_cnt[0]);
        v.ask_count = COUNT_BITS'(shadow_cnt[1]);
        return v;
    endfunction

    task automatic queue_item(input book_op_t o, input book_side_t s,
                              input logic [PRICE_BITS-1:0] p, input logic [QTY_BITS-1:0] q);
        book_item_t it;
        it.op = o;
        it.side = s;
        it.price = p;
        it.qty = q;
        pending_items.push_back(it);
    endtask

    function automatic logic [QTY_BITS-1:0] pick_qty();
        case ($urandom_range(0, 3))
            0: return QTY_MAX;
            1: return QTY_BITS'($urandom_range(1, 100));
            default: return ($urandom == 0) ? 1 : $urandom;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= 1'b0;
            side <= 1'b0;
            level_price <= '0;
            level_quantity <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_views.push_back(predict_book_view(driven_item));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    driven_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    op <= driven_item.op;
                    side <= driven_item.side;
                    level_price <= driven_item.price;
                    level_quantity <= driven_item.qty;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        book_view_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                    note_mismatch("result with no transaction pending");
                else
                begin
                    want = expected_views.pop_front();
                    if (status !== want.status)
                        note_mismatch($sformatf("status got %0d want %0d", status, want.status));
                    if (best_bid_price !== want.bid_price)
                        note_mismatch($sformatf("best_bid_price got %0d want %0d",
                                                best_bid_price, want.bid_price));
                    if (best_bid_quantity !== want.bid_qty)
                        note_mismatch($sformatf("best_bid_quantity got %0d want %0d",
                                                best_bid_quantity, want.bid_qty));
                    if (best_ask_price !== want.ask_price)
                        note_mismatch($sformatf("best_ask_price got %0d want %0d",
                                                best_ask_price, want.ask_price));
                    if (best_ask_quantity !== want.ask_qty)
                        note_mismatch($sformatf("best_ask_quantity got %0d want %0d",
                                                best_ask_quantity, want.ask_qty));
                    if (bid_levels !== want.bid_count)
                        note_mismatch($sformatf("bid_levels got %0d want %0d",
                                                bid_levels, want.bid_count));
                    if (ask_levels !== want.ask_count)
                        note_mismatch($sformatf("ask_levels got %0d want %0d",
                                                ask_levels, want.ask_count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int burst;
        int span;
        int remove_pct;
        logic [PRICE_BITS-1:0] base;
        book_side_t s;

        shadow_cnt[0] = 0;
        shadow_cnt[1] = 0;

        // directed
        queue_item(OP_CLEAR, SIDE_ASK, PRICE_MAX, QTY_MAX);
        queue_item(OP_LEVEL, SIDE_BID, '0, '0);
        queue_item(OP_LEVEL, SIDE_ASK, PRICE_MAX, '0);
        queue_item(OP_LEVEL, SIDE_BID, 100, 5);
        queue_item(OP_LEVEL, SIDE_BID, '0, QTY_MAX);
        queue_item(OP_LEVEL, SIDE_BID, PRICE_MAX, 1);
        queue_item(OP_LEVEL, SIDE_BID, PRICE_MAX, 7);
        queue_item(OP_LEVEL, SIDE_BID, 50, 3);
        queue_item(OP_LEVEL, SIDE_ASK, PRICE_MAX, QTY_MAX);
        queue_item(OP_LEVEL, SIDE_ASK, '0, 1);
        queue_item(OP_LEVEL, SIDE_ASK, 200, 9);
        queue_item(OP_LEVEL, SIDE_ASK, '0, QTY_MAX);
        queue_item(OP_LEVEL, SIDE_ASK, '0, '0);
        queue_item(OP_LEVEL, SIDE_BID, 50, '0);
        queue_item(OP_LEVEL, SIDE_BID, 77, '0);
        queue_item(OP_LEVEL, SIDE_BID, PRICE_MAX, '0);
        queue_item(OP_LEVEL, SIDE_ASK, PRICE_MAX, '0);
        queue_item(OP_CLEAR, SIDE_BID, '0, '0);
        queue_item(OP_LEVEL, SIDE_ASK, 10, 1);
        queue_item(OP_LEVEL, SIDE_BID, 100, 2);

        // fill both sides to the limit, then push past it
        queue_item(OP_CLEAR, SIDE_BID, '0, '0);
        for (int k = 0; k < 2; k++)
        begin
            s = (k == 0) ? SIDE_BID : SIDE_ASK;
            base = $urandom;
            for (int i = 0; i < LEVELS; i++)
                queue_item(OP_LEVEL, s, base + PRICE_BITS'(((i * 37) % LEVELS) * 5), pick_qty());
            for (int i = 0; i < 3; i++)
                queue_item(OP_LEVEL, s, base + PRICE_BITS'(LEVELS * 5 + i), pick_qty());
            queue_item(OP_LEVEL, s, base + 5, pick_qty());
            queue_item(OP_LEVEL, s, base + PRICE_BITS'(LEVELS * 5 + 9), '0);
            queue_item(OP_LEVEL, s, base + 10, '0);
            queue_item(OP_LEVEL, s, base + 11, pick_qty());
            queue_item(OP_LEVEL, s, base + 12, pick_qty());
        end
        queue_item(OP_CLEAR, SIDE_ASK, $urandom, $urandom);

        // random bursts over narrow price bands so levels collide and fill
        while (pending_items.size() < 1800)
        begin
            burst = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0: span = 3;
                1: span = 20;
                default: span = 90;
            endcase
            remove_pct = $urandom_range(5, 45);
            base = $urandom;
            if ($urandom_range(0, 2) == 0)
                queue_item(OP_CLEAR, book_side_t'($urandom_range(0, 1)), $urandom, $urandom);
            for (int i = 0; i < burst; i++)
            begin
                s = book_side_t'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 2)
                    queue_item(OP_CLEAR, s, $urandom, $urandom);
                else if ($urandom_range(0, 99) < 4)
                    queue_item(OP_LEVEL, s, $urandom,
                               ($urandom_range(0, 99) < remove_pct) ? '0 : pick_qty());
                else
                    queue_item(OP_LEVEL, s, base + PRICE_BITS'($urandom_range(0, span)),
                               ($urandom_range(0, 99) < remove_pct) ? '0 : pick_qty());
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_views.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
